[hdl/vlpd_pkg.sv]
package vlpd_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 32;
    localparam int MAXLEN_W  = 21;
    localparam int GROUP_W   = 7;
    localparam int HDR_CNT_W = 3;

    localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = {MAXLEN_W{1'b1}};

    // Index of the continuation flag inside a header byte.
    localparam int MORE_BIT = 7;

    // Index of the last header byte (the fifth); a further continuation is an error.
    localparam logic [HDR_CNT_W-1:0] LAST_HDR_IDX = 3'd4;

    // Length value that is treated like zero: a frame without payload.
    localparam logic [LEN_W-1:0] SPECIAL_EMPTY = 32'h0000_00FE;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TOO_LONG = 2'd1,
        STATUS_OVER_MAX = 2'd2
    } status_t;

endpackage

[hdl/vlpd_ifs.sv]
interface vlpd_byte_if
    import vlpd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface vlpd_result_if
    import vlpd_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [BYTE_W-1:0]       out_byte;
    logic                    is_header;
    logic                    frame_last;
    logic                    length_valid;
    logic signed [LEN_W-1:0] frame_length;
    status_t                 status;

    modport source (output valid, output out_byte, output is_header, output frame_last,
                    output length_valid, output frame_length, output status,
                    input ready);
    modport sink   (input valid, input out_byte, input is_header, input frame_last,
                    input length_valid, input frame_length, input status,
                    output ready);
endinterface

interface vlpd_cfg_if
    import vlpd_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [MAXLEN_W-1:0] max_payload_length;

    modport source (output valid, output max_payload_length, input ready);
    modport sink   (input valid, input max_payload_length, output ready);
endinterface

[hdl/varint_length_prefix_deframer.sv]
// Channel      Direction  Payload
// -----------  ---------  -------------------------------------------------------------
// byte_in      sink       in_byte
// result_out   source     out_byte, is_header, frame_last, length_valid, frame_length,
//                         status
// cfg          sink       max_payload_length
//
// One request is accepted per clock cycle unless byte_in is stalled; its result appears
// in the output register on the next cycle. The rate is set by the single decode step
// between the frame state and the result register. byte_in is ready whenever the result
// register is empty or is being taken in the same cycle. rst_n clears the frame state
// and restores the maximum length to its largest value; cfg is always ready.
module varint_length_prefix_deframer
    import vlpd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    vlpd_byte_if.sink     byte_in,
    vlpd_result_if.source result_out,
    vlpd_cfg_if.sink      cfg
);

    // Frame state.
    logic                 in_payload_reg,  in_payload_next;
    logic [HDR_CNT_W-1:0] hdr_cnt_reg,     hdr_cnt_next;
    logic [LEN_W-1:0]     acc_reg,         acc_next;
    logic [MAXLEN_W-1:0]  remaining_reg,   remaining_next;
    logic [MAXLEN_W-1:0]  max_len_reg;

    // Result register.
    logic                 out_valid_reg;
    logic [BYTE_W-1:0]    out_byte_reg,    out_byte_next;
    logic                 is_header_reg,   is_header_next;
    logic                 frame_last_reg,  frame_last_next;
    logic                 length_valid_reg, length_valid_next;
    logic [LEN_W-1:0]     frame_length_reg, frame_length_next;
    status_t              status_reg,      status_next;

    logic                 accept;
    logic [LEN_W-1:0]     group_ext;
    logic [LEN_W-1:0]     group_shifted;
    logic [LEN_W-1:0]     acc_merged;

    // The output register frees up when it is empty or drained this cycle.
    assign byte_in.ready = !out_valid_reg || result_out.ready;
    assign accept        = byte_in.valid && byte_in.ready;
    assign cfg.ready     = 1'b1;

    // Place the 7-bit group of the current header byte; the top group of the fifth
    // byte loses the bits that do not fit into 32 bits.
    assign group_ext = {{(LEN_W-GROUP_W){1'b0}}, byte_in.in_byte[GROUP_W-1:0]};

    always_comb
    begin
        case (hdr_cnt_reg)
            3'd0:    group_shifted = group_ext;
            3'd1:    group_shifted = group_ext << GROUP_W;
            3'd2:    group_shifted = group_ext << (2*GROUP_W);
            3'd3:    group_shifted = group_ext << (3*GROUP_W);
            default: group_shifted = group_ext << (4*GROUP_W);
        endcase
    end

    assign acc_merged = acc_reg | group_shifted;

    // Decode of one byte against the current frame state.
    always_comb
    begin
        in_payload_next   = in_payload_reg;
        hdr_cnt_next      = hdr_cnt_reg;
        acc_next          = acc_reg;
        remaining_next    = remaining_reg;

        out_byte_next     = byte_in.in_byte;
        is_header_next    = 1'b0;
        frame_last_next   = 1'b0;
        length_valid_next = 1'b0;
        frame_length_next = acc_reg;
        status_next       = STATUS_OK;

        if (in_payload_reg)
        begin
            if (remaining_reg <= MAXLEN_W'(1))
            begin
                // Last payload byte closes the frame.
                frame_last_next = 1'b1;
                in_payload_next = 1'b0;
                hdr_cnt_next    = '0;
                acc_next        = '0;
                remaining_next  = '0;
            end
            else
            begin
                remaining_next = remaining_reg - MAXLEN_W'(1);
            end
        end
        else
        begin
            is_header_next    = 1'b1;
            frame_length_next = acc_merged;
            acc_next          = acc_merged;
            if (byte_in.in_byte[MORE_BIT])
            begin
                if (hdr_cnt_reg == LAST_HDR_IDX)
                begin
                    // Header still continues after five bytes: drop it and hunt again.
                    status_next    = STATUS_TOO_LONG;
                    hdr_cnt_next   = '0;
                    acc_next       = '0;
                    remaining_next = '0;
                end
                else
                begin
                    hdr_cnt_next = hdr_cnt_reg + HDR_CNT_W'(1);
                end
            end
            else
            begin
                length_valid_next = 1'b1;
                if (acc_merged == '0 || acc_merged == SPECIAL_EMPTY
                    || acc_merged[LEN_W-1])
                begin
                    // Zero, the special empty value or a negative length: no payload.
                    frame_last_next = 1'b1;
                    hdr_cnt_next    = '0;
                    acc_next        = '0;
                    remaining_next  = '0;
                end
                else if (acc_merged > {{(LEN_W-MAXLEN_W){1'b0}}, max_len_reg})
                begin
                    // Too large for the configured limit: flag it and hunt for the next header.
                    status_next    = STATUS_OVER_MAX;
                    hdr_cnt_next   = '0;
                    acc_next       = '0;
                    remaining_next = '0;
                end
                else
                begin
                    in_payload_next = 1'b1;
                    hdr_cnt_next    = '0;
                    remaining_next  = acc_merged[MAXLEN_W-1:0];
                end
            end
        end
    end

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_payload_reg <= 1'b0;
            hdr_cnt_reg    <= '0;
            acc_reg        <= '0;
            remaining_reg  <= '0;
            max_len_reg    <= MAXLEN_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                max_len_reg <= cfg.max_payload_length;
            end
            if (accept)
            begin
                in_payload_reg <= in_payload_next;
                hdr_cnt_reg    <= hdr_cnt_next;
                acc_reg        <= acc_next;
                remaining_reg  <= remaining_next;
                out_valid_reg  <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is qualified by out_valid_reg.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_byte_reg     <= out_byte_next;
            is_header_reg    <= is_header_next;
            frame_last_reg   <= frame_last_next;
            length_valid_reg <= length_valid_next;
            frame_length_reg <= frame_length_next;
            status_reg       <= status_next;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.out_byte     = out_byte_reg;
    assign result_out.is_header    = is_header_reg;
    assign result_out.frame_last   = frame_last_reg;
    assign result_out.length_valid = length_valid_reg;
    assign result_out.frame_length = signed'(frame_length_reg);
    assign result_out.status       = status_reg;

endmodule

[sim/deframer_checker.sv]
module deframer_checker
    import vlpd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    vlpd_byte_if   byte_in,
    vlpd_result_if result_out,
    vlpd_cfg_if    cfg,
    output int     mismatches,
    output int     outstanding,
    output int     results_seen,
    output logic   at_frame_start
);

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              hdr;
        logic              last;
        logic              len_done;
        logic [LEN_W-1:0]  flen;
        status_t           st;
    } byte_tag_t;

    // Frame decoder state, mirrored from the stream seen on byte_in.
    logic                 in_frame;
    logic [HDR_CNT_W-1:0] hdr_count;
    logic [LEN_W-1:0]     len_acc;
    logic [MAXLEN_W-1:0]  remaining;
    logic [MAXLEN_W-1:0]  max_len;

    byte_tag_t tags_due[$];
    byte_tag_t oldest;

    function automatic void go_hunting();
        in_frame  = 1'b0;
        hdr_count = '0;
        len_acc   = '0;
        remaining = '0;
    endfunction

    function automatic byte_tag_t tag_byte(input logic [BYTE_W-1:0] b);
        byte_tag_t t;
        int        shift;
        t.data     = b;
        t.hdr      = 1'b0;
        t.last     = 1'b0;
        t.len_done = 1'b0;
        t.st       = STATUS_OK;
        if (in_frame)
        begin
            t.flen = len_acc;
            if (remaining <= MAXLEN_W'(1))
            begin
                t.last = 1'b1;
                go_hunting();
            end
            else
            begin
                remaining = remaining - MAXLEN_W'(1);
            end
        end
        else
        begin
            t.hdr = 1'b1;
            // The fifth group lands at bit 28; its upper three bits fall off.
            shift   = GROUP_W * hdr_count;
            len_acc = len_acc | (LEN_W'(b[GROUP_W-1:0]) << shift);
            t.flen  = len_acc;
            if (b[MORE_BIT])
            begin
                if (hdr_count == LAST_HDR_IDX)
                begin
                    t.st = STATUS_TOO_LONG;
                    go_hunting();
                end
                else
                begin
                    hdr_count = hdr_count + HDR_CNT_W'(1);
                end
            end
            else
            begin
                t.len_done = 1'b1;
                if (len_acc == '0 || len_acc == SPECIAL_EMPTY || len_acc[LEN_W-1])
                begin
                    t.last = 1'b1;
                    go_hunting();
                end
                else if (len_acc > LEN_W'(max_len))
                begin
                    t.st = STATUS_OVER_MAX;
                    go_hunting();
                end
                else
                begin
                    in_frame  = 1'b1;
                    hdr_count = '0;
                    remaining = len_acc[MAXLEN_W-1:0];
                end
            end
        end
        return t;
    endfunction

    function automatic void check_field(input string field, input longint want,
                                        input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len = MAXLEN_RESET;
            go_hunting();
            tags_due.delete();
            mismatches     = 0;
            outstanding    = 0;
            results_seen   = 0;
            at_frame_start = 1'b1;
        end
        else
        begin
            if (result_out.valid && result_out.ready)
            begin
                results_seen++;
                if (tags_due.size() == 0)
                begin
                    $error("result with out_byte %0d arrived with no request pending",
                           result_out.out_byte);
                    mismatches++;
                end
                else
                begin
                    oldest = tags_due.pop_front();
                    check_field("out_byte", oldest.data, result_out.out_byte);
                    check_field("is_header", oldest.hdr, result_out.is_header);
                    check_field("frame_last", oldest.last, result_out.frame_last);
                    check_field("length_valid", oldest.len_done, result_out.length_valid);
                    check_field("frame_length", $signed(oldest.flen),
                                result_out.frame_length);
                    check_field("status", int'(oldest.st), int'(result_out.status));
                end
            end
            if (byte_in.valid && byte_in.ready)
                tags_due.push_back(tag_byte(byte_in.in_byte));
            if (cfg.valid && cfg.ready)
                max_len = cfg.max_payload_length;
            outstanding    = tags_due.size();
            at_frame_start = !in_frame && hdr_count == '0;
        end
    end

endmodule

[sim/tb_varint_length_prefix_deframer.sv]
// Top level of the deframer bench. It only makes stimulus and gives the verdict;
// deframer_checker sits beside the block, follows every request on the byte,
// result and configuration channels, and keeps the running failure count.
module tb_varint_length_prefix_deframer;
    import vlpd_pkg::*;

    logic clk = 1'b0;
    logic rst_n;

    always #2 clk = ~clk;

    vlpd_byte_if   byte_in();
    vlpd_result_if result_out();
    vlpd_cfg_if    cfg();

    int   mismatches;
    int   outstanding;
    int   results_seen;
    logic at_frame_start;

    varint_length_prefix_deframer uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .result_out (result_out),
        .cfg        (cfg)
    );

    deframer_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_in        (byte_in),
        .result_out     (result_out),
        .cfg            (cfg),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .results_seen   (results_seen),
        .at_frame_start (at_frame_start)
    );

    // Idling mix of the current phase, in percent of cycles.
    int send_idle_pct;
    int stall_pct;

    // The maximum length that the block holds right now. Stimulus uses it to
    // decide whether a header will be followed by payload.
    logic [MAXLEN_W-1:0] cur_max;

    int bytes_sent;
    int frames_sent;
    int max_writes;

    // Opening bytes: an empty frame, the length 254 spread over two bytes, a
    // one-byte and a two-byte payload, a header that never ends, a negative
    // length whose fifth group carries bits that fall off the top, and the
    // first length above the reset maximum.
    logic [BYTE_W-1:0] opening_bytes [22] = '{
        8'h00,
        8'hFE, 8'h01,
        8'h01, 8'hFF,
        8'h02, 8'h00, 8'h80,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'h80, 8'h80, 8'h80, 8'h80, 8'h78,
        8'h80, 8'h80, 8'h80, 8'h01
    };

    // The receiver decides anew at every falling edge whether it takes a result.
    always @(negedge clk)
    begin
        result_out.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Offers one byte, after a random number of idle cycles, and holds it until
    // the block takes the request. Returns at the falling edge after acceptance
    // with valid still high, so the next byte can follow without a gap.
    task automatic push_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_in.valid <= 1'b0;
            @(negedge clk);
        end
        byte_in.valid   <= 1'b1;
        byte_in.in_byte <= b;
        do
            @(posedge clk);
        while (!byte_in.ready);
        @(negedge clk);
        bytes_sent++;
    endtask

    // Stops sending and waits until every result that is owed has come out.
    // The block gives one result per byte, so nothing else can be in flight.
    task automatic drain();
        byte_in.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_max(input logic [MAXLEN_W-1:0] value);
        drain();
        cfg.valid              <= 1'b1;
        cfg.max_payload_length <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 1'b0;
        cur_max = value;
        max_writes++;
    endtask

    function automatic int header_groups(input logic [LEN_W-1:0] len);
        int n;
        n = 1;
        while (n < 5 && (len >> (GROUP_W * n)) != 0)
            n++;
        return n;
    endfunction

    // Sends a length header of the given number of groups. With overrun set the
    // last group keeps its continuation flag, which makes a header too long.
    task automatic send_header(input logic [LEN_W-1:0] len, input int groups,
                               input bit overrun);
        logic [BYTE_W-1:0] b;
        for (int i = 0; i < groups; i++)
        begin
            b[GROUP_W-1:0] = GROUP_W'(len >> (GROUP_W * i));
            // Only four bits of the fifth group fit; fill the rest with junk.
            if (i == 4)
                b[GROUP_W-1:4] = 3'($urandom);
            b[MORE_BIT] = overrun || (i < groups - 1);
            push_byte(b);
        end
    endtask

    // A whole frame: its header, shortest form or padded with empty groups, and
    // the payload when the block is going to take one.
    task automatic send_frame(input logic [LEN_W-1:0] len, input bit padded);
        int groups;
        groups = header_groups(len);
        if (padded)
            groups = $urandom_range(groups, 5);
        send_header(len, groups, 1'b0);
        if (!(len == '0 || len == SPECIAL_EMPTY || len[LEN_W-1]) && len <= LEN_W'(cur_max))
            repeat (len) push_byte(8'($urandom));
        frames_sent++;
    endtask

    task automatic random_frame();
        int                pick;
        int                hi;
        logic [LEN_W-1:0]  len;
        pick = $urandom_range(99);
        if (pick < 4)
        begin
            send_frame('0, 1'($urandom));
        end
        else if (pick < 8)
        begin
            send_frame(SPECIAL_EMPTY, 1'($urandom));
        end
        else if (pick < 12)
        begin
            send_frame($urandom | 32'h8000_0000, 1'b0);
        end
        else if (pick < 20)
        begin
            // Just above the maximum, or well above it.
            len = LEN_W'(cur_max) + 1 + $urandom_range(0, (pick < 16) ? 0 : 100000);
            send_frame(len, 1'($urandom));
        end
        else if (pick < 24)
        begin
            send_header($urandom, 5, 1'b1);
        end
        else if (pick < 30 && cur_max <= 1000)
        begin
            // Garbage or a cut-off frame. These are only sent while the maximum
            // is small, so a stray header cannot open an endless payload.
            if (pick < 27 || cur_max < 2)
            begin
                repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
            end
            else
            begin
                len = $urandom_range(2, (cur_max < 50) ? cur_max : 50);
                send_header(len, header_groups(len), 1'b0);
                repeat ($urandom_range(1, len - 1)) push_byte(8'($urandom));
            end
            // Feed short bytes until the decoder is back at a frame boundary.
            while (!at_frame_start)
                push_byte({1'b0, 7'($urandom)});
        end
        else
        begin
            hi = ($urandom_range(9) == 0) ? 300 : 16;
            if (cur_max < hi)
                hi = cur_max;
            len = (hi == 0) ? $urandom_range(1, 16) : $urandom_range(1, hi);
            send_frame(len, $urandom_range(4) == 0);
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input int count);
        int target;
        send_idle_pct = idle;
        stall_pct     = stall;
        target        = bytes_sent + count;
        while (bytes_sent < target)
        begin
            random_frame();
            // Now and then the sender holds off until the block is empty.
            if ($urandom_range(99) == 0)
                drain();
        end
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        byte_in.valid          = 1'b0;
        byte_in.in_byte        = '0;
        cfg.valid              = 1'b0;
        cfg.max_payload_length = '0;
        send_idle_pct          = 0;
        stall_pct              = 0;
        cur_max                = MAXLEN_RESET;
        bytes_sent             = 0;
        frames_sent            = 0;
        max_writes             = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (opening_bytes[i])
            push_byte(opening_bytes[i]);

        // Each phase pairs an idling mix with a maximum length; zero, one and the
        // full 21-bit value are the extremes of the register.
        run_phase(0, 0, 300);
        write_max('0);
        run_phase(60, 0, 150);
        write_max(21'd1);
        run_phase(0, 60, 150);
        write_max(21'd300);
        run_phase(13, 13, 300);
        write_max(MAXLEN_W'($urandom_range(1, 2097151)));
        run_phase(60, 0, 250);
        write_max(MAXLEN_RESET);
        run_phase(0, 60, 250);
        write_max(21'd1000);
        run_phase(13, 13, 200);

        drain();
        repeat (4) @(negedge clk);
        $display("Sent %0d bytes in %0d well-formed frames plus noise; %0d results checked.",
                 bytes_sent, frames_sent, results_seen);
        $display("Wrote the maximum length %0d times, from zero up to the full 21 bits.",
                 max_writes);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: far more time than the slowest correct run could take.
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
